>>> design/dcr_pkg.sv
package dcr_pkg;

    localparam int RAW_W  = 12;
    localparam int OUT_W  = 16;
    localparam int GAIN_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd5;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

>>> design/dcr_ifs.sv
interface dcr_in_if;
    logic                      valid;
    logic                      ready;
    logic [dcr_pkg::RAW_W-1:0] raw_sample;
    logic                      last_sample;

    modport source (output valid, output raw_sample, output last_sample, input ready);
    modport sink   (input valid, input raw_sample, input last_sample, output ready);
endinterface

interface dcr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dcr_pkg::OUT_W-1:0] centered_value;
    logic                             last_out;

    modport source (output valid, output centered_value, output last_out, input ready);
    modport sink   (input valid, input centered_value, input last_out, output ready);
endinterface

interface dcr_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dcr_pkg::GAIN_W-1:0] gain_shift;

    modport source (output valid, output gain_shift, input ready);
    modport sink   (input valid, input gain_shift, output ready);
endinterface

>>> design/dcr_store.sv
module dcr_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 12,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/dcr_div.sv
module dcr_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 7,
    parameter int QUO_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial      = {rem_reg, quo_reg[NUM_W-1]};
        fits       = (trial >= {1'b0, den_reg});
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        steps_next = steps_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            den_next   = divisor;
            steps_next = STEP_W'(NUM_W);
        end
        else if (steps_reg != '0)
        begin
            quo_next   = {quo_reg[NUM_W-2:0], fits};
            rem_next   = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            steps_next = steps_reg - STEP_W'(1);
            done_next  = (steps_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUO_W-1:0];

endmodule

>>> design/block_dc_removal_q15_unit.sv
// Block DC-offset removal with a Q15 gain shift.
//
// samples (sink): one converter sample per transaction, last_sample closes the block.
// A block also closes by itself once it holds MAX_SAMPLES samples.
// results (source): one centered value per stored sample, in arrival order, last_out
// on the final one. Value = (sample - floor(sum / count)) << gain_shift, low 16 bits.
// cfg (sink): gain_shift write, always ready; write only while the block is idle.
//
// While loading, samples.ready is high and every valid sample is stored. After the
// closing transaction the bias comes from a restoring divider, one quotient bit per
// cycle. Emitting then reads the sample memory once per result, and with a free
// receiver one result leaves per cycle. samples.ready is low from the close until the
// last result has entered the output register. The results output is registered; a
// stalled receiver holds it and stops the memory reads, nothing is dropped. Reset
// clears the sum, count, and state and sets gain_shift to 5; the sample memory is
// not cleared, only written entries are read.
module block_dc_removal_q15_unit #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    dcr_in_if.sink    samples,
    dcr_out_if.source results,
    dcr_cfg_if.sink   cfg
);

    import dcr_pkg::*;

    localparam int SMP_W = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SMP_W + CNT_W;
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_shift_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [SMP_W-1:0]  bias_reg;
    logic              start_reg;
    logic              pend_reg, pend_next;
    logic              pend_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_value_reg;
    logic              out_last_reg;

    logic              in_ready;
    logic              emit_active;
    logic              in_acc;
    logic              close_blk;
    logic [SMP_W-1:0]  smp;
    logic              issue;
    logic              move;
    logic              blk_done;
    logic              div_done;
    logic [SMP_W-1:0]  div_quo;
    logic [SMP_W-1:0]  rd_data;
    logic [OUT_W-1:0]  diff;

    // --- configuration: always ready; the user must write it only while idle, the block itself leaves this unenforced
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_shift_reg <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            gain_shift_reg <= cfg.gain_shift;
        end
    end

    // --- load side
    assign smp       = samples.raw_sample[SMP_W-1:0];
    assign in_acc    = samples.valid && in_ready;
    assign close_blk = samples.last_sample || (cnt_reg + CNT_W'(1) == CNT_W'(MAX_SAMPLES));

    // --- emit side: one memory read in flight, then the output register
    assign move     = pend_reg && (!out_valid_reg || results.ready);
    assign issue    = emit_active && (rd_idx_reg != cnt_reg) && (!pend_reg || move);
    assign blk_done = move && pend_last_reg;
    assign diff     = OUT_W'(rd_data) - OUT_W'(bias_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && close_blk)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (blk_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready    = 1'b0;
        emit_active = 1'b0;
        case (state_reg)
            ST_LOAD: in_ready    = 1'b1;
            ST_EMIT: emit_active = 1'b1;
            default:
            begin
                in_ready    = 1'b0;
                emit_active = 1'b0;
            end
        endcase
    end

    // accumulate while loading, clear when the last result enters the output register; emit read index and flags
    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (in_acc)
        begin
            sum_next = sum_reg + SUM_W'(smp);
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (blk_done)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
        if (div_done)
        begin
            rd_idx_next = '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        if (issue)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            start_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            start_reg     <= in_acc && close_blk;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            bias_reg <= div_quo;
        end
        if (issue)
        begin
            pend_last_reg <= (rd_idx_reg + CNT_W'(1) == cnt_reg);
        end
        if (move)
        begin
            out_value_reg <= diff << gain_shift_reg;
            out_last_reg  <= pend_last_reg;
        end
    end

    assign samples.ready          = in_ready;
    assign results.valid          = out_valid_reg;
    assign results.centered_value = out_value_reg;
    assign results.last_out       = out_last_reg;

    dcr_store #(
        .DEPTH (MAX_SAMPLES),
        .WIDTH (SMP_W),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (smp),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    dcr_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W),
        .QUO_W (SMP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

>>> design/dcr_checker.sv
module dcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_value,
    input logic        out_last
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("result changed while stalled");

    // no new samples while a block is still being emitted
    a_no_load_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready during block emission");

    // a closing transaction with last_sample stops the input for the bias computation
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still ready after block close");

endmodule

bind block_dc_removal_q15_unit dcr_checker u_dcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_last   (samples.last_sample),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.centered_value),
    .out_last  (results.last_out)
);
